// ===== rtl/core/orkv_pkg.sv =====
// Package for the ordered key-value table: state codes and result codes.
// Used by ordered_key_value_table_unit; depends on nothing.
package orkv_pkg;

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_SRCH     = 11'b000_0000_0010,
      ST_SRCH_CMP = 11'b000_0000_0100,
      ST_CHK      = 11'b000_0000_1000,
      ST_DEL_RD   = 11'b000_0001_0000,
      ST_DEL_WR   = 11'b000_0010_0000,
      ST_INS_RD   = 11'b000_0100_0000,
      ST_INS_WR   = 11'b000_1000_0000,
      ST_FINAL_WR = 11'b001_0000_0000,
      ST_OUT_WAIT = 11'b010_0000_0000,
      ST_DONE     = 11'b100_0000_0000
   } state_type;

   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_NONE = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam logic [1:0] EFF_INSERTED = 2'd0;
   localparam logic [1:0] EFF_REPLACED = 2'd1;
   localparam logic [1:0] EFF_DELETED  = 2'd2;
   localparam logic [1:0] EFF_NOTHING  = 2'd3;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

endpackage

// ===== rtl/core/ordered_key_value_table_unit.sv =====
// A request runs a binary search over the entries (a first read and a read of an empty
// table skip it); inserts and deletes then move each shifted entry with a read state
// and a write state. One item at a time: a request is taken only when idle, after the
// last result has entered the output register, which waits on rsp_ready while full.
// Reset (synchronous, active high) empties the table and unplaces the cursor;
// the memory itself is not cleared, only slots below the count are ever read.
// Ordered key-value table: sorted key/value memory with binary search and a
// read cursor. Depends on orkv_pkg.
module ordered_key_value_table_unit
   import orkv_pkg::*;
#(
   parameter int ENTRIES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic signed [31:0] req_key_in,
   input  logic signed [31:0] req_data_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [1:0]         rsp_write_effect,
   output logic signed [31:0] rsp_key_out,
   output logic signed [31:0] rsp_data_out,
   input  logic               csr_write_enable,
   input  logic               csr_write_data
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

   // Sorted store: slots 0 .. count-1 hold keys in ascending signed order.
   logic [31:0] key_mem [ENTRIES];
   logic [31:0] val_mem [ENTRIES];
   logic        wr_en;
   logic [IW-1:0] wr_addr;
   logic [31:0] wr_key, wr_val;
   logic        rd_en;
   logic [IW-1:0] rd_addr;
   logic [31:0] rd_key_ff, rd_val_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         val_mem[wr_addr] <= wr_val;
      end
      if (rd_en) begin
         rd_key_ff <= key_mem[rd_addr];
         rd_val_ff <= val_mem[rd_addr];
      end
   end

   state_type state_ff, state_in;
   logic order_ff, order_in;          // walk direction register
   logic func_ff, func_in;
   logic dir_ff, dir_in;              // direction latched for this item
   logic le_ff, le_in;                // search advances past equal keys
   logic [31:0] key_ff, key_in;
   logic [31:0] data_ff, data_in;
   logic [31:0] tgt_ff, tgt_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, idx_ff, idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] mid_ff, mid_in;
   logic cur_valid_ff, cur_valid_in;
   logic [31:0] cur_key_ff, cur_key_in;
   logic [1:0] res_status_ff, res_status_in, res_eff_ff, res_eff_in;
   logic [31:0] res_key_ff, res_key_in, res_data_ff, res_data_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in, rsp_eff_ff, rsp_eff_in;
   logic [31:0] rsp_key_ff, rsp_key_in, rsp_data_ff, rsp_data_in;

   logic [CW:0] mid_sum;
   logic [CW-1:0] mid_full;
   logic adv;

   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_full = mid_sum[CW:1];
   assign adv = ($signed(rd_key_ff) < $signed(tgt_ff)) || (le_ff && (rd_key_ff == tgt_ff));

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      order_in      = csr_write_enable ? csr_write_data : order_ff;
      func_in       = func_ff;
      dir_in        = dir_ff;
      le_in         = le_ff;
      key_in        = key_ff;
      data_in       = data_ff;
      tgt_in        = tgt_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      idx_in        = idx_ff;
      mid_in        = mid_ff;
      count_in      = count_ff;
      cur_valid_in  = cur_valid_ff;
      cur_key_in    = cur_key_ff;
      res_status_in = res_status_ff;
      res_eff_in    = res_eff_ff;
      res_key_in    = res_key_ff;
      res_data_in   = res_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_eff_in    = rsp_eff_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_data_in   = rsp_data_ff;
      wr_en   = 1'b0;
      wr_addr = lo_ff[IW-1:0];
      wr_key  = key_ff;
      wr_val  = data_ff;
      rd_en   = 1'b0;
      rd_addr = mid_full[IW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in       = req_func;
               dir_in        = order_ff;
               key_in        = req_key_in;
               data_in       = req_data_in;
               lo_in         = '0;
               hi_in         = count_ff;
               res_status_in = STATUS_DONE;
               res_eff_in    = EFF_NOTHING;
               res_key_in    = '0;
               res_data_in   = '0;
               if (req_func == FUNC_WRITE) begin
                  tgt_in   = req_key_in;
                  le_in    = 1'b0;
                  state_in = ST_SRCH;
               end else if (count_ff == '0) begin
                  res_status_in = STATUS_NONE;
                  state_in      = ST_DONE;
               end else if (!cur_valid_ff) begin
                  // First read: fetch minimum or maximum slot directly.
                  rd_en    = 1'b1;
                  rd_addr  = order_ff ? IW'(count_ff - 1'b1) : '0;
                  state_in = ST_OUT_WAIT;
               end else begin
                  tgt_in   = cur_key_ff;
                  le_in    = !order_ff;
                  state_in = ST_SRCH;
               end
            end
         end
         ST_SRCH: begin
            if (lo_ff < hi_ff) begin
               rd_en    = 1'b1;
               mid_in   = mid_full[IW-1:0];
               state_in = ST_SRCH_CMP;
            end else if (func_ff == FUNC_WRITE) begin
               if (lo_ff < count_ff) begin
                  rd_en    = 1'b1;
                  rd_addr  = lo_ff[IW-1:0];
                  state_in = ST_CHK;
               end else if (data_ff == '0) begin
                  state_in = ST_DONE;
               end else if (count_ff >= FULL_COUNT) begin
                  res_status_in = STATUS_FULL;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_FINAL_WR;
               end
            end else if (!dir_ff) begin
               if (lo_ff < count_ff) begin
                  rd_en    = 1'b1;
                  rd_addr  = lo_ff[IW-1:0];
                  state_in = ST_OUT_WAIT;
               end else begin
                  res_status_in = STATUS_NONE;
                  state_in      = ST_DONE;
               end
            end else begin
               if (lo_ff != '0) begin
                  rd_en    = 1'b1;
                  rd_addr  = IW'(lo_ff - 1'b1);
                  state_in = ST_OUT_WAIT;
               end else begin
                  res_status_in = STATUS_NONE;
                  state_in      = ST_DONE;
               end
            end
         end
         ST_SRCH_CMP: begin
            if (adv) lo_in = CW'({1'b0, mid_ff}) + 1'b1;
            else     hi_in = CW'({1'b0, mid_ff});
            state_in = ST_SRCH;
         end
         ST_CHK: begin
            if (rd_key_ff == key_ff) begin
               if (data_ff == '0) begin
                  res_eff_in = EFF_DELETED;
                  idx_in     = lo_ff;
                  if ({1'b0, lo_ff} + 1'b1 < {1'b0, count_ff}) begin
                     state_in = ST_DEL_RD;
                  end else begin
                     count_in = count_ff - 1'b1;
                     state_in = ST_DONE;
                  end
               end else begin
                  wr_en      = 1'b1;
                  res_eff_in = EFF_REPLACED;
                  state_in   = ST_DONE;
               end
            end else if (data_ff == '0) begin
               state_in = ST_DONE;
            end else if (count_ff >= FULL_COUNT) begin
               res_status_in = STATUS_FULL;
               state_in      = ST_DONE;
            end else begin
               idx_in   = count_ff;
               state_in = ST_INS_RD;
            end
         end
         ST_DEL_RD: begin
            rd_en    = 1'b1;
            rd_addr  = IW'(idx_ff + 1'b1);
            state_in = ST_DEL_WR;
         end
         ST_DEL_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[IW-1:0];
            wr_key  = rd_key_ff;
            wr_val  = rd_val_ff;
            idx_in  = idx_ff + 1'b1;
            if ({1'b0, idx_ff} + 2'd2 < {1'b0, count_ff}) begin
               state_in = ST_DEL_RD;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_INS_RD: begin
            rd_en    = 1'b1;
            rd_addr  = IW'(idx_ff - 1'b1);
            state_in = ST_INS_WR;
         end
         ST_INS_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[IW-1:0];
            wr_key  = rd_key_ff;
            wr_val  = rd_val_ff;
            idx_in  = idx_ff - 1'b1;
            state_in = ((idx_ff - 1'b1) > lo_ff) ? ST_INS_RD : ST_FINAL_WR;
         end
         ST_FINAL_WR: begin
            wr_en      = 1'b1;
            count_in   = count_ff + 1'b1;
            res_eff_in = EFF_INSERTED;
            state_in   = ST_DONE;
         end
         ST_OUT_WAIT: begin
            cur_valid_in = 1'b1;
            cur_key_in   = rd_key_ff;
            res_key_in   = rd_key_ff;
            res_data_in  = rd_val_ff;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            // Hand the item to the output register once it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_eff_in    = res_eff_ff;
               rsp_key_in    = res_key_ff;
               rsp_data_in   = res_data_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         order_ff     <= 1'b0;
         count_ff     <= '0;
         cur_valid_ff <= 1'b0;
         cur_key_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         order_ff     <= order_in;
         count_ff     <= count_in;
         cur_valid_ff <= cur_valid_in;
         cur_key_ff   <= cur_key_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      dir_ff        <= dir_in;
      le_ff         <= le_in;
      key_ff        <= key_in;
      data_ff       <= data_in;
      tgt_ff        <= tgt_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      idx_ff        <= idx_in;
      mid_ff        <= mid_in;
      res_status_ff <= res_status_in;
      res_eff_ff    <= res_eff_in;
      res_key_ff    <= res_key_in;
      res_data_ff   <= res_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_eff_ff    <= rsp_eff_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_write_effect = rsp_eff_ff;
   assign rsp_key_out      = rsp_key_ff;
   assign rsp_data_out     = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT) else $error("entry count above capacity");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         ((count_ff == $past(count_ff) + 1'b1) || (count_ff == $past(count_ff) - 1'b1)))
      else $error("entry count moved by more than one");
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !wr_en) else $error("memory write while idle");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff != 2'd3)) else $error("bad status code");
`endif

endmodule
